>>> src/nlms_pkg.sv
// Shared types, constants and a helper function of the normalized LMS filter core.
// Used by nlms_div, the top level, the checker and the testbench; depends on nothing else.
package nlms_pkg;

    // Operation codes carried in the op field of a request.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    // Configuration register indexes (byte address / 4).
    localparam logic REG_STEP_SIZE    = 1'b0;
    localparam logic REG_OUTPUT_SHIFT = 1'b1;

    // Saturation limits of a Q31 value, held at 64 bits.
    localparam logic signed [63:0] Q31_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q31_MIN = -64'sd2147483648;

    // Reciprocal numerator (2^31-1)*2^31: the partial remainder after its top
    // 29 bits, and the 33 low bits that are brought down one per step.
    localparam logic [31:0] RECIP_REM0 = 32'h1FFF_FFFF;
    localparam logic [32:0] RECIP_LOW  = 33'h1_8000_0000;
    localparam logic [30:0] RECIP_MAX  = 31'h7FFF_FFFF;
    localparam logic [4:0]  NORM_LIMIT = 5'd30;
    localparam logic [5:0]  DIV_LAST   = 6'd32;

    typedef struct packed {
        logic               op;
        logic signed [31:0] sample;
        logic signed [31:0] reference;
        logic [4:0]         coef_index;
        logic signed [31:0] coef_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] filter_out;
        logic signed [31:0] error_out;
    } t_out;

    // Result of the reciprocal unit.
    typedef struct packed {
        logic        done;
        logic [30:0] inv;
        logic [4:0]  sh;
    } t_div_res;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_EN1, S_EN2, S_EN3, S_FIR, S_ERR, S_EMU, S_EMU2,
        S_DIVW, S_WMUL, S_WSAT, S_UPD, S_FIN
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE, D_NORM, D_DIV
    } t_div_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > Q31_MAX) begin
            return Q31_MAX[31:0];
        end else if (v < Q31_MIN) begin
            return Q31_MIN[31:0];
        end
        return v[31:0];
    endfunction

endpackage

>>> src/nlms_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module nlms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/nlms_mul.sv
// Shared signed 32x32 multiplier with a registered 64-bit product.
// No dependencies.
module nlms_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> src/nlms_div.sv
// Reciprocal unit: normalizes energy+1 one bit a cycle, then divides the
// Q62 numerator by it one quotient bit a cycle. Depends on nlms_pkg.
module nlms_div import nlms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_arg,
    output t_div_res           o_res
);

    t_div_state  r_state, n_state;
    logic [30:0] r_arg;
    logic [4:0]  r_sh;
    logic [31:0] r_rem;
    logic [32:0] r_q;
    logic [32:0] r_dbits;
    logic [5:0]  r_cnt;
    logic        r_done;
    logic [31:0] trial;
    logic        fits;

    assign trial = {r_rem[30:0], r_dbits[32]};
    assign fits  = trial >= {1'b0, r_arg};

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: begin
                if (i_start && !i_arg[31] && (i_arg != 32'sd0)) begin
                    n_state = D_NORM;
                end
            end
            D_NORM: begin
                if (r_arg[30] || (r_sh == NORM_LIMIT)) begin
                    n_state = D_DIV;
                end
            end
            D_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = D_IDLE;
                end
            end
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                // A non-positive argument finishes at once.
                r_done <= i_arg[31] || (i_arg == 32'sd0);
            end else if ((r_state == D_DIV) && (r_cnt == DIV_LAST)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_arg <= i_arg[30:0];
                    r_sh  <= 5'd0;
                    r_q   <= {2'b00, RECIP_MAX};
                end
            end
            D_NORM: begin
                if (!r_arg[30] && (r_sh != NORM_LIMIT)) begin
                    r_arg <= {r_arg[29:0], 1'b0};
                    r_sh  <= r_sh + 5'd1;
                end else begin
                    if (r_sh != 5'd0) begin
                        r_sh <= r_sh - 5'd1;
                    end
                    r_rem   <= RECIP_REM0;
                    r_dbits <= RECIP_LOW;
                    r_cnt   <= 6'd0;
                    r_q     <= 33'd0;
                end
            end
            D_DIV: begin
                r_rem   <= fits ? (trial - {1'b0, r_arg}) : trial;
                r_q     <= {r_q[31:0], fits};
                r_dbits <= {r_dbits[31:0], 1'b0};
                r_cnt   <= r_cnt + 6'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.done = r_done;
        o_res.sh   = r_sh;
        o_res.inv  = (r_q[32:31] != 2'b00) ? RECIP_MAX : r_q[30:0];
    end

endmodule

>>> src/normalized_lms_filter_q31_core.sv
// Top level of the Q31 normalized LMS adaptive FIR filter core.
// Depends on nlms_pkg, nlms_ram, nlms_mul and nlms_div.
//
// Usage:
// Requests enter on i_in with i_in_valid / o_in_ready. A request with op set
// writes one coefficient (ignored when the index is not below TAPS) and is
// finished in the cycle it is accepted; it produces no result. A request with
// op clear pushes a sample into the delay line, updates the running energy,
// filters, adapts all coefficients and produces one result on o_out with
// o_out_valid / i_out_ready.
// A sample request takes longer the more normalizing shifts energy+1 needs,
// up to the full 30 shifts; a non-positive energy+1 skips the division. The
// core is ready again in the cycle in which the result appears on o_out. The
// time is set by two passes over the taps through the one shared multiplier
// (one tap a cycle, each with a fill and a drain) and by the reciprocal unit,
// which normalizes energy+1 one shift at a time, finishes normalizing and then
// forms its quotient one bit at a time.
// The block takes no new request while a sample is being worked on.
// The result sits in an output register; the core may take the next request
// while it waits, and only holds at the very end of the next sample until the
// receiver has taken the earlier result.
// After reset the core clears both coefficient and delay line memories, one
// entry a cycle, over all TAPS entries; o_in_ready stays low meanwhile, but the
// register port takes writes at any time. Registers step_size (address 0)
// and output_shift (address 4) should only be written while the core is idle.
module normalized_lms_filter_q31_core import nlms_pkg::*; #(
    parameter int TAPS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = $clog2(TAPS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
    localparam logic [CW-1:0] TAP_COUNT = CW'(TAPS);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_idx;
    logic [AW-1:0]      r_dptr;
    logic [AW-1:0]      r_head;
    logic               r_v1, r_v2, r_f1;
    logic [AW-1:0]      r_a1, r_a2;
    logic signed [31:0] r_c2;
    logic [31:0]        r_energy;
    logic signed [31:0] r_leave, r_lead;
    logic [63:0]        r_acc;
    logic signed [31:0] r_x, r_ref, r_e, r_emu, r_w, r_y;
    logic [30:0]        r_step;
    logic [4:0]         r_oshift;
    t_out               r_out;
    logic               r_out_valid;

    // Memory ports.
    logic               dl_we, cf_we;
    logic [AW-1:0]      dl_waddr, cf_waddr;
    logic [31:0]        dl_wdata, cf_wdata;
    logic [31:0]        dl_rd, cf_rd;

    // Shared multiplier.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    // Reciprocal unit.
    logic               div_start;
    t_div_res           div_res;

    logic               accept, issue, pass_done, out_free, cfg_wr;
    logic [AW-1:0]      tail;
    logic [63:0]        en_sub, en_add;
    logic [63:0]        acc_sh;
    logic signed [31:0] y_val;
    logic signed [63:0] w_sh;
    logic signed [63:0] upd_sum;

    assign accept    = i_in_valid && o_in_ready;
    assign issue     = ((r_state == S_FIR) || (r_state == S_UPD)) && (r_idx != TAP_COUNT);
    assign pass_done = (r_idx == TAP_COUNT) && !r_v1 && !r_v2;
    assign out_free  = !r_out_valid || i_out_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign tail      = (r_head == '0) ? LAST_ADDR : (r_head - AW'(1));

    // Energy steps: drop the square of the leaving sample, add the new one.
    assign en_sub  = {r_energy, 32'd0} - {prod[62:0], 1'b0};
    assign en_add  = {r_energy, 32'd0} + {prod[62:0], 1'b0};
    // Output shift: 31 - s equals ~s on five bits.
    assign acc_sh  = r_acc >> (~r_oshift);
    assign y_val   = acc_sh[31:0];
    assign w_sh    = prod >>> (~div_res.sh);
    assign upd_sum = 64'(r_c2) + (64'($signed(prod[63:32])) <<< 1);

    nlms_ram #(.WIDTH(32), .DEPTH(TAPS), .AW(AW)) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (dl_waddr),
        .i_wdata (dl_wdata),
        .i_raddr (r_dptr),
        .o_rdata (dl_rd)
    );

    nlms_ram #(.WIDTH(32), .DEPTH(TAPS), .AW(AW)) u_cf_ram (
        .i_clk   (i_clk),
        .i_we    (cf_we),
        .i_waddr (cf_waddr),
        .i_wdata (cf_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (cf_rd)
    );

    nlms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    nlms_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_arg   ($signed(r_energy + 32'd1)),
        .o_res   (div_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_idx == CW'(TAPS - 1)) n_state = S_IDLE;
            S_IDLE: if (accept && (i_in.op == OP_SAMPLE)) n_state = S_EN1;
            S_EN1:  n_state = S_EN2;
            S_EN2:  n_state = S_EN3;
            S_EN3:  n_state = S_FIR;
            S_FIR:  if (pass_done) n_state = S_ERR;
            S_ERR:  n_state = S_EMU;
            S_EMU:  n_state = S_EMU2;
            S_EMU2: n_state = S_DIVW;
            S_DIVW: if (div_res.done) n_state = S_WMUL;
            S_WMUL: n_state = S_WSAT;
            S_WSAT: n_state = S_UPD;
            S_UPD:  if (pass_done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath steering for the current state.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        div_start  = (r_state == S_ERR);
        dl_we      = 1'b0;
        dl_waddr   = tail;
        dl_wdata   = i_in.sample;
        cf_we      = 1'b0;
        cf_waddr   = r_a2;
        cf_wdata   = sat32(upd_sum);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_CLR: begin
                dl_we    = 1'b1;
                dl_waddr = r_idx[AW-1:0];
                dl_wdata = '0;
                cf_we    = 1'b1;
                cf_waddr = r_idx[AW-1:0];
                cf_wdata = '0;
            end
            S_IDLE: begin
                dl_we = i_in_valid && (i_in.op == OP_SAMPLE);
                if (i_in_valid && (i_in.op == OP_COEF) && (32'(i_in.coef_index) < TAPS)) begin
                    cf_we    = 1'b1;
                    cf_waddr = AW'(i_in.coef_index);
                    cf_wdata = i_in.coef_value;
                end
            end
            S_EN1: begin
                mul_a = r_leave;
                mul_b = r_leave;
            end
            S_EN2: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_FIR: begin
                mul_a = dl_rd;
                mul_b = cf_rd;
            end
            S_EMU: begin
                mul_a = r_e;
                mul_b = $signed({1'b0, r_step});
            end
            S_WMUL: begin
                mul_a = r_emu;
                mul_b = $signed({1'b0, div_res.inv});
            end
            S_UPD: begin
                mul_a = r_w;
                mul_b = dl_rd;
                cf_we = r_v2;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_head      <= '0;
            r_energy    <= '0;
            r_leave     <= '0;
            r_step      <= '0;
            r_oshift    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_STEP_SIZE:    r_step   <= pwdata[30:0];
                    REG_OUTPUT_SHIFT: r_oshift <= pwdata[4:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_CLR) || issue) begin
                r_idx <= r_idx + CW'(1);
            end else if ((r_state == S_EN3) || (r_state == S_WSAT)) begin
                r_idx <= '0;
            end
            if (r_state == S_EN2) begin
                r_energy <= en_sub[63:32];
            end else if (r_state == S_EN3) begin
                r_energy <= en_add[63:32];
            end
            if ((r_state == S_FIN) && out_free) begin
                // The delay line shifts by one: the oldest slot becomes the newest.
                r_head      <= (r_head == LAST_ADDR) ? '0 : (r_head + AW'(1));
                r_leave     <= r_lead;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a1 <= r_idx[AW-1:0];
        r_f1 <= (r_idx == '0);
        r_a2 <= r_a1;
        r_c2 <= cf_rd;
        if (accept) begin
            r_x   <= i_in.sample;
            r_ref <= i_in.reference;
        end
        if ((r_state == S_EN3) || (r_state == S_WSAT)) begin
            r_dptr <= r_head;
        end else if (issue) begin
            r_dptr <= (r_dptr == LAST_ADDR) ? '0 : (r_dptr + AW'(1));
        end
        if (r_state == S_EN3) begin
            r_acc <= '0;
        end else if ((r_state == S_FIR) && r_v2) begin
            r_acc <= r_acc + prod;
        end
        if ((r_state == S_FIR) && r_v1 && r_f1) begin
            r_lead <= dl_rd;
        end
        if (r_state == S_ERR) begin
            r_y <= y_val;
            r_e <= r_ref - y_val;
        end
        // The output register only changes once the earlier result is taken.
        if ((r_state == S_FIN) && out_free) begin
            r_out.filter_out <= r_y;
            r_out.error_out  <= r_e;
        end
        if (r_state == S_EMU2) begin
            r_emu <= prod[62:31];
        end
        if (r_state == S_WSAT) begin
            r_w <= sat32(w_sh);
        end
    end

    always_comb begin
        case (paddr[2])
            REG_STEP_SIZE:    prdata = {1'b0, r_step};
            REG_OUTPUT_SHIFT: prdata = {27'd0, r_oshift};
            default:          prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

>>> src/nlms_chk.sv
// Port-level checker for the normalized LMS filter core, bound to the top level.
// Depends on nlms_pkg and normalized_lms_filter_q31_core.
module nlms_chk import nlms_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in         i_in,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out        o_out,
    input logic        pready
);

    // A sample request keeps the core busy in the following cycle.
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in.op == OP_SAMPLE)) |=> !o_in_ready)
        else $error("core ready right after a sample request");

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed or dropped");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind normalized_lms_filter_q31_core nlms_chk u_nlms_chk (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the Q31 normalized LMS filter core: a queue-fed driver, a stall
// pattern on the result side, and an in-bench filter model that checks every result.
// Depends on nlms_pkg and normalized_lms_filter_q31_core.
module tb;
    import nlms_pkg::*;

    localparam int TAPS = 32;
    localparam int LIMIT = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out        o_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #4 i_clk = ~i_clk;

    normalized_lms_filter_q31_core #(.TAPS(TAPS)) DUT (.*);

    // Model state of the filter, its registers included.
    logic signed [63:0] taps_hist [TAPS];
    logic signed [63:0] weights [TAPS];
    logic [31:0]        energy;
    logic signed [63:0] dropped;
    logic [30:0]        mu;
    logic [4:0]         post_shift;

    t_in  pending_reqs [$];
    t_out expected_results [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   burst_on = 1'b0;
    int   burst_left = 0;

    function automatic logic signed [63:0] sat_q31(input logic signed [63:0] v);
        if (v > Q31_MAX) return Q31_MAX;
        if (v < Q31_MIN) return Q31_MIN;
        return v;
    endfunction

    // Computes the result of one sample request and advances the model state.
    function automatic t_out filter_step(input t_in req);
        logic signed [63:0] x, acc, y, e, arg, inv, emu, w, c;
        logic [63:0]        t;
        int                 sh;
        t_out               res;
        x = req.sample;
        taps_hist[TAPS-1] = x;
        t = {energy, 32'h0} - ((dropped * dropped) << 1);
        energy = t[63:32];
        t = {energy, 32'h0} + ((x * x) << 1);
        energy = t[63:32];
        acc = '0;
        for (int i = 0; i < TAPS; i++) acc += taps_hist[i] * weights[i];
        y = $signed(acc[31 - post_shift +: 32]);
        e = $signed(32'(req.reference - y[31:0]));
        arg = $signed(32'(energy + 32'd1));
        sh = 0;
        if (arg <= 0) begin
            inv = 64'sd2147483647;
        end else begin
            while (arg < 64'sd1073741824 && sh < 30) begin
                arg = arg <<< 1;
                sh++;
            end
            if (sh > 0) sh--;
            inv = (64'sd2147483647 * 64'sd2147483648) / arg;
            if (inv > 64'sd2147483647) inv = 64'sd2147483647;
        end
        emu = (e * $signed({33'b0, mu})) >>> 31;
        w = sat_q31((emu * inv) >>> (31 - sh));
        for (int i = 0; i < TAPS; i++) begin
            c = (w * taps_hist[i]) >>> 32;
            weights[i] = sat_q31(weights[i] + 2 * c);
        end
        dropped = taps_hist[0];
        for (int i = 0; i < TAPS - 1; i++) taps_hist[i] = taps_hist[i+1];
        res.filter_out = y[31:0];
        res.error_out = e[31:0];
        return res;
    endfunction

    // Driver: bursts of back-to-back requests separated by random gaps.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_in_valid && o_in_ready) begin
            if (i_in.op == OP_COEF) begin
                if (i_in.coef_index < TAPS) weights[i_in.coef_index] = i_in.coef_value;
            end else begin
                expected_results.push_back(filter_step(i_in));
            end
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (burst_left > 0) begin
                burst_left <= burst_left - 1;
            end else begin
                burst_on <= ~burst_on;
                burst_left <= burst_on ? $urandom_range(0, 6) : $urandom_range(1, 20);
            end
            if (burst_on && pending_reqs.size() > 0) begin
                i_in <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: the receiver stalls in a pattern of its own; each result is checked.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_out);
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out.filter_out !== exp_res.filter_out
                        || o_out.error_out !== exp_res.error_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp out %h err %h, got out %h err %h",
                            exp_res.filter_out, exp_res.error_out,
                            o_out.filter_out, o_out.error_out);
                    end
                end
            end
        end
        i_out_ready <= (cycles % 64 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Register write with a setup and an access phase; the model takes the value at the same time.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(REG_STEP_SIZE * 4)) mu = value[30:0];
        else post_shift = value[4:0];
    endtask

    // Waits until every request is taken and every result is back, plus the
    // coefficient writes that follow the last sample.
    task automatic drain();
        while (!(pending_reqs.size() == 0 && !i_in_valid && expected_results.size() == 0))
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic t_in rand_req(input int coef_pct, input bit big);
        t_in r;
        r.op = ($urandom_range(0, 99) < coef_pct) ? OP_COEF : OP_SAMPLE;
        r.sample = $urandom;
        if (!big) r.sample = $signed(r.sample) >>> $urandom_range(0, 20);
        r.reference = $urandom;
        r.coef_index = 5'($urandom);
        r.coef_value = $urandom;
        if (!big) r.coef_value = $signed(r.coef_value) >>> $urandom_range(0, 12);
        return r;
    endfunction

    initial begin
        t_in r;
        logic [31:0] mu_set [5];
        logic [31:0] sh_set [5];
        for (int i = 0; i < TAPS; i++) begin
            taps_hist[i] = '0;
            weights[i] = '0;
        end
        energy = '0;
        dropped = '0;
        mu = '0;
        post_shift = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(3'(REG_STEP_SIZE * 4), 32'h4000_0000);
        write_reg(3'(REG_OUTPUT_SHIFT * 4), 32'd0);

        // Directed: coefficient extremes, an out-of-range-free index sweep corner,
        // sample extremes that drive the energy to wrap and saturate the weights.
        r = '0;
        r.op = OP_COEF;
        r.coef_index = 5'd31; r.coef_value = 32'h7FFF_FFFF; pending_reqs.push_back(r);
        r.coef_index = 5'd0;  r.coef_value = 32'h8000_0000; pending_reqs.push_back(r);
        r.coef_index = 5'd30; r.coef_value = 32'hFFFF_FFFF; pending_reqs.push_back(r);
        r = '0;
        r.op = OP_SAMPLE;
        r.sample = 32'h8000_0000; r.reference = 32'h7FFF_FFFF; pending_reqs.push_back(r);
        r.sample = 32'h7FFF_FFFF; r.reference = 32'h8000_0000; pending_reqs.push_back(r);
        r.sample = 32'h8000_0000; r.reference = 32'h8000_0000; pending_reqs.push_back(r);
        r.sample = 32'h0; r.reference = 32'h0; pending_reqs.push_back(r);
        r.sample = 32'h1; r.reference = 32'hFFFF_FFFF; pending_reqs.push_back(r);
        r.sample = 32'hFFFF_FFFF; r.reference = 32'h7FFF_FFFF; pending_reqs.push_back(r);
        for (int i = 0; i < 8; i++) pending_reqs.push_back(rand_req(0, 1));
        drain();

        // Random phases over several register settings, the extremes among them.
        mu_set = '{32'h7FFF_FFFF, 32'h0, 32'h0100_0000, 32'h2000_0000, 32'h7FFF_FFFF};
        sh_set = '{32'd30, 32'd31, 32'd8, 32'd0, 32'd17};
        foreach (mu_set[p]) begin
            write_reg(3'(REG_STEP_SIZE * 4), mu_set[p] | ($urandom & 32'h8000_0000));
            write_reg(3'(REG_OUTPUT_SHIFT * 4), sh_set[p] | ($urandom & 32'hFFFF_FFE0));
            for (int i = 0; i < 325; i++) pending_reqs.push_back(rand_req(25, $urandom_range(0, 3) == 0));
            drain();
        end
        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/nlms_pkg.sv
src/nlms_ram.sv
src/nlms_mul.sv
src/nlms_div.sv
src/normalized_lms_filter_q31_core.sv
src/nlms_chk.sv
dv/tb.sv
